// ===== hw/rtl/spa_pkg.sv =====
// Package for the surface pool allocator: widths, codes and shared types.
`timescale 1ns / 1ps
package spa_pkg;

    localparam int CNT_W     = 8;
    localparam int STAMP_W   = 32;
    localparam int IDX_OUT_W = 5;
    localparam int ACT_W     = 6;

    localparam logic [ACT_W-1:0] ACT_RESET = 6'd6;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_REL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REL,
        ST_GRANT
    } t_state;

    // verdict of the scan unit on one entry
    typedef struct packed {
        logic is_free;
        logic take_oldest;
    } t_scan_res;

endpackage

// ===== hw/rtl/spa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/spa_scan_unit.sv =====
// Shared scan unit: free test on a count and age compare against the oldest so far.
`timescale 1ns / 1ps
module spa_scan_unit (
    input  logic [spa_pkg::CNT_W-1:0]   i_count,
    input  logic [spa_pkg::STAMP_W-1:0] i_stamp,
    input  logic                        i_first,
    input  logic [spa_pkg::STAMP_W-1:0] i_oldest_stamp,
    output spa_pkg::t_scan_res          o_res
);
    import spa_pkg::*;

    always_comb begin
        o_res.is_free     = (i_count == '0);
        // unsigned compare; strict less keeps the lowest index on ties
        o_res.take_oldest = i_first || (i_stamp < i_oldest_stamp);
    end

endmodule

// ===== hw/rtl/surface_pool_allocator_top.sv =====
// Top level of the surface pool allocator: sequencer, entry stores and valid bits.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-----------------------------------
//  request   | start / busy        | i_kind, i_release_index
//  result    | o_strobe (1 cycle)  | o_granted_index, o_reused_busy
//  config    | i_cfg_we            | i_cfg_wdata (active count)
//
// A release holds busy for one cycle after acceptance; a release beyond the pool
// leaves busy low. A get reads one entry per cycle from the count and stamp RAMs
// and walks it through the one scan unit over entries 0 .. (clamped active count) - 1,
// stopping at the first free entry; the result follows in the grant state.
// Reset and a config write clear per-entry valid bits at once; no clearing pass.
// The receiver cannot stall: the result shows for exactly one cycle.
`timescale 1ns / 1ps
module surface_pool_allocator_top #(
    parameter int POOL_SIZE = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_kind,
    input  logic [spa_pkg::IDX_OUT_W-1:0] i_release_index,
    input  logic                          i_cfg_we,
    input  logic [spa_pkg::ACT_W-1:0]     i_cfg_wdata,
    output logic                          o_strobe,
    output logic [spa_pkg::IDX_OUT_W-1:0] o_granted_index,
    output logic                          o_reused_busy
);
    import spa_pkg::*;

    localparam int IW = $clog2(POOL_SIZE);
    localparam logic [ACT_W:0] POOL_W = (ACT_W+1)'(POOL_SIZE);

    t_state r_state, n_state;
    logic   r_strobe, n_strobe;
    logic [ACT_W-1:0]     r_active, n_active;
    logic [STAMP_W-1:0]   r_stamp, n_stamp;
    logic [POOL_SIZE-1:0] r_cnt_vld, n_cnt_vld;
    logic [POOL_SIZE-1:0] r_stm_vld, n_stm_vld;
    logic [IW-1:0]        r_idx, n_idx;
    logic [IW-1:0]        r_pick, n_pick;
    logic                 r_reused, n_reused;
    logic [IW-1:0]        r_old_idx, n_old_idx;
    logic [STAMP_W-1:0]   r_old_stamp, n_old_stamp;

    logic [ACT_W:0]       act_ext, eff_cnt;
    logic [IW-1:0]        last_idx;
    logic                 accept, rel_in_range, at_last;

    logic [IW-1:0]        ram_raddr, ram_waddr;
    logic                 cnt_we, stm_we;
    logic [CNT_W-1:0]     cnt_wdata, cnt_q, cnt_cur;
    logic [STAMP_W-1:0]   stm_wdata, stm_q, stm_cur;
    t_scan_res            scan_res;

    assign accept       = start && (r_state == ST_IDLE);
    assign rel_in_range = ((ACT_W+1)'(i_release_index) < POOL_W);

    // active count zero scans entry 0; above the pool it clamps
    assign act_ext  = (ACT_W+1)'(r_active);
    assign eff_cnt  = (act_ext == '0) ? (ACT_W+1)'(1)
                    : ((act_ext > POOL_W) ? POOL_W : act_ext);
    assign last_idx = IW'(eff_cnt - 1'b1);
    assign at_last  = (r_idx == last_idx);

    assign cnt_cur = r_cnt_vld[r_idx] ? cnt_q : '0;
    assign stm_cur = r_stm_vld[r_idx] ? stm_q : '0;

    spa_ram #(.WIDTH(CNT_W), .DEPTH(POOL_SIZE)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (ram_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (cnt_q)
    );

    spa_ram #(.WIDTH(STAMP_W), .DEPTH(POOL_SIZE)) u_stm_ram (
        .i_clk   (i_clk),
        .i_we    (stm_we),
        .i_waddr (ram_waddr),
        .i_wdata (stm_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (stm_q)
    );

    spa_scan_unit u_scan (
        .i_count        (cnt_cur),
        .i_stamp        (stm_cur),
        .i_first        (r_idx == '0),
        .i_oldest_stamp (r_old_stamp),
        .o_res          (scan_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_REL) begin
                        n_state = rel_in_range ? ST_REL : ST_IDLE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_res.is_free || at_last) begin
                    n_state = ST_GRANT;
                end
            end
            ST_REL:   n_state = ST_IDLE;
            ST_GRANT: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // RAM controls
    always_comb begin
        ram_raddr = IW'(r_idx + 1'b1);
        ram_waddr = r_idx;
        cnt_we    = 1'b0;
        stm_we    = 1'b0;
        cnt_wdata = cnt_cur - 1'b1;
        stm_wdata = r_stamp;
        case (r_state)
            ST_IDLE: begin
                ram_raddr = (i_kind == KIND_REL) ? IW'(i_release_index) : '0;
            end
            ST_SCAN: begin
                ram_raddr = IW'(r_idx + 1'b1);
            end
            ST_REL: begin
                cnt_we = 1'b1;
            end
            ST_GRANT: begin
                ram_waddr = r_pick;
                cnt_we    = 1'b1;
                stm_we    = 1'b1;
                cnt_wdata = CNT_W'(1);
            end
            default: begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_active    = r_active;
        n_stamp     = r_stamp;
        n_cnt_vld   = r_cnt_vld;
        n_stm_vld   = r_stm_vld;
        n_idx       = r_idx;
        n_pick      = r_pick;
        n_reused    = r_reused;
        n_old_idx   = r_old_idx;
        n_old_stamp = r_old_stamp;
        n_strobe    = (r_state == ST_SCAN) && (n_state == ST_GRANT);
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx = (i_kind == KIND_REL) ? IW'(i_release_index) : '0;
                end
            end
            ST_SCAN: begin
                if (scan_res.take_oldest) begin
                    n_old_idx   = r_idx;
                    n_old_stamp = stm_cur;
                end
                n_idx = IW'(r_idx + 1'b1);
                if (scan_res.is_free) begin
                    n_pick   = r_idx;
                    n_reused = 1'b0;
                end else if (at_last) begin
                    n_pick   = scan_res.take_oldest ? r_idx : r_old_idx;
                    n_reused = 1'b1;
                end
            end
            ST_REL: begin
                n_cnt_vld[r_idx] = 1'b1;
            end
            ST_GRANT: begin
                n_stamp           = r_stamp + 1'b1;
                n_cnt_vld[r_pick] = 1'b1;
                n_stm_vld[r_pick] = 1'b1;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
        if (i_cfg_we) begin
            n_active  = i_cfg_wdata;
            n_cnt_vld = '0;
            n_stm_vld = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_strobe  <= 1'b0;
            r_active  <= ACT_RESET;
            r_stamp   <= '0;
            r_cnt_vld <= '0;
            r_stm_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_strobe  <= n_strobe;
            r_active  <= n_active;
            r_stamp   <= n_stamp;
            r_cnt_vld <= n_cnt_vld;
            r_stm_vld <= n_stm_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pick      <= n_pick;
        r_reused    <= n_reused;
        r_old_idx   <= n_old_idx;
        r_old_stamp <= n_old_stamp;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_strobe        = r_strobe;
    assign o_granted_index = IDX_OUT_W'(r_pick);
    assign o_reused_busy   = r_reused;

endmodule

// ===== hw/rtl/spa_checker.sv =====
// Port-level checks for the surface pool allocator, bound to the top level.
`timescale 1ns / 1ps
module spa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_kind,
    input logic                          o_strobe,
    input logic [spa_pkg::IDX_OUT_W-1:0] o_granted_index
);
    import spa_pkg::*;

    // a result is given while the get is still in progress
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while not busy");

    // an accepted get always occupies the block: busy is raised once it is taken
    a_get_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_GET) |=> busy)
        else $error("get accepted but block not busy next cycle");

    // no result can appear in the cycle right after an item is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result too soon after acceptance");

    // one result per get: the strobe is a single cycle, then the block frees up
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> (!o_strobe && !busy))
        else $error("strobe longer than one cycle or block stuck busy");

    // the granted index carries known bits whenever the strobe is up
    a_index_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !$isunknown(o_granted_index))
        else $error("granted index unknown on strobe");

endmodule

bind surface_pool_allocator_top spa_checker u_spa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_kind          (i_kind),
    .o_strobe        (o_strobe),
    .o_granted_index (o_granted_index)
);
